### src/assert_macros.svh
// Assertion macros shared by the I2C bit sequencer RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/i2cmbs_pkg.sv
// Types, codes and the step decoder of the I2C master bit sequencer.
// No dependencies; used by i2c_master_bit_sequencer_unit.
`timescale 1ns / 1ps
package i2cmbs_pkg;

  // Operation carried with each input transfer
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // Command in progress; codes match the operation that launched it
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // One pin action per tick
  typedef enum logic [2:0] {
    ACT_CLK0     = 3'd0,
    ACT_CLK1     = 3'd1,
    ACT_REL      = 3'd2,
    ACT_PULL     = 3'd3,
    ACT_DBIT     = 3'd4,
    ACT_CLK1_ACK = 3'd5,
    ACT_CLK1_BIT = 3'd6,
    ACT_CLK0_SHL = 3'd7
  } act_t;

  typedef struct packed {
    act_t act;
    logic last;
  } act_sel_t;

  localparam int unsigned StepW  = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TdataW = 16;
  localparam int unsigned OpW    = 3;

  // Last step index of the write and read commands
  localparam logic [StepW-1:0] StepLastWrite  = 6'd27;
  localparam logic [StepW-1:0] StepLastReadAk = 6'd21;
  localparam logic [StepW-1:0] StepLastReadNk = 6'd20;

  // Result fields of one transfer
  typedef struct packed {
    logic             cmd_error;
    logic             ack_seen;
    logic [ByteW-1:0] rx_byte;
    logic             done_res;
    logic             busy_res;
    logic             sda_pull_low;
    logic             scl_level;
  } result_t;

  // Decode the pin action for the current step of a command
  function automatic act_sel_t pick_action(cmd_t cmd, logic [StepW-1:0] step,
                                           logic no_ack);
    act_sel_t s;
    s.act  = ACT_CLK0;
    s.last = 1'b0;
    unique case (cmd)
      CMD_START: begin
        s.last = (step[1:0] == 2'd3);
        case (step[1:0])
          2'd0:    s.act = ACT_CLK0;
          2'd1:    s.act = ACT_REL;
          2'd2:    s.act = ACT_CLK1;
          default: s.act = ACT_PULL;
        endcase
      end
      CMD_STOP: begin
        s.last = (step[1:0] == 2'd3);
        case (step[1:0])
          2'd0:    s.act = ACT_CLK0;
          2'd1:    s.act = ACT_PULL;
          2'd2:    s.act = ACT_CLK1;
          default: s.act = ACT_REL;
        endcase
      end
      CMD_WRITE: begin
        // Data bits take three steps each: set SDA, SCL high, SCL low and shift
        case (step) inside
          6'd0:                                         s.act = ACT_CLK0;
          6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22:
                                                        s.act = ACT_DBIT;
          6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17, 6'd20, 6'd23:
                                                        s.act = ACT_CLK1;
          6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24:
                                                        s.act = ACT_CLK0_SHL;
          6'd25:                                        s.act = ACT_REL;
          6'd26:                                        s.act = ACT_CLK1_ACK;
          default: begin
            s.act  = ACT_CLK0;
            s.last = 1'b1;
          end
        endcase
      end
      CMD_READ: begin
        if (step == 6'd0) begin
          s.act = ACT_CLK0;
        end else if (step == 6'd1) begin
          s.act = ACT_REL;
        end else if (step <= 6'd17) begin
          // Even steps raise SCL and sample, odd steps lower it
          s.act = step[0] ? ACT_CLK0 : ACT_CLK1_BIT;
        end else if (!no_ack) begin
          case (step)
            6'd18:   s.act = ACT_PULL;
            6'd19:   s.act = ACT_CLK1;
            6'd20:   s.act = ACT_CLK0;
            default: begin
              s.act  = ACT_REL;
              s.last = 1'b1;
            end
          endcase
        end else begin
          case (step)
            6'd18:   s.act = ACT_REL;
            6'd19:   s.act = ACT_CLK1;
            default: begin
              s.act  = ACT_CLK0;
              s.last = 1'b1;
            end
          endcase
        end
      end
      default: begin
        s.act  = ACT_CLK0;
        s.last = 1'b0;
      end
    endcase
    return s;
  endfunction

endpackage

### src/i2c_master_bit_sequencer_unit.sv
// I2C master bit sequencer with an open-drain SDA line: top level.
// Depends on i2cmbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// The block accepts one transfer per clock while in_tready is high and returns
// exactly one registered result transfer for each. A command transfer (start,
// stop, write, read) launches only while idle, else its result flags cmd_error;
// each following tick transfer performs one pin action and the result shows
// SCL, the SDA pull-down and the status after it. A two-entry output buffer
// (result register plus skid register) keeps input acceptance going while a
// result waits, so in_tready only drops after two results are left untaken.
`include "assert_macros.svh"

module i2c_master_bit_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] tx_byte, [8] last_read, [9] sda_in, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] scl_level, [1] sda_pull_low, [2] busy_res,
                                  // [3] done_res, [11:4] rx_byte, [12] ack_seen,
                                  // [13] cmd_error, rest zero
);

  localparam int unsigned StepW = i2cmbs_pkg::StepW;
  localparam int unsigned ByteW = i2cmbs_pkg::ByteW;

  // Sequencer state
  i2cmbs_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic [ByteW-1:0]   shift_r, shift_nxt;
  logic [ByteW-1:0]   rx_r, rx_nxt;
  logic               no_ack_r, no_ack_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_low_r, sda_low_nxt;
  logic               ack_r, ack_nxt;

  // Output buffer
  logic                  out_valid_r;
  i2cmbs_pkg::result_t   out_data_r;
  logic                  skid_valid_r;
  i2cmbs_pkg::result_t   skid_data_r;

  i2cmbs_pkg::result_t   res_nxt;
  i2cmbs_pkg::act_sel_t  sel;
  i2cmbs_pkg::op_t       op;
  logic [ByteW-1:0]      tx_byte;
  logic                  last_read;
  logic                  sda_in;
  logic                  in_fire;
  logic                  done;
  logic                  err;

  // Refuse transfers during reset and while the skid register is full
  assign in_tready = rst_n & ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;

  // Unpack the input transfer
  assign op        = i2cmbs_pkg::op_t'(in_tuser);
  assign tx_byte   = in_tdata[7:0];
  assign last_read = in_tdata[8];
  assign sda_in    = in_tdata[9];

  assign sel = i2cmbs_pkg::pick_action(cmd_r, step_r, no_ack_r);

  // Next state and result of the accepted transfer
  always_comb begin
    cmd_nxt     = cmd_r;
    step_nxt    = step_r;
    shift_nxt   = shift_r;
    rx_nxt      = rx_r;
    no_ack_nxt  = no_ack_r;
    scl_nxt     = scl_r;
    sda_low_nxt = sda_low_r;
    ack_nxt     = ack_r;
    done        = 1'b0;
    err         = 1'b0;
    if (in_fire) begin
      case (op) inside
        i2cmbs_pkg::OP_START, i2cmbs_pkg::OP_STOP,
        i2cmbs_pkg::OP_WRITE, i2cmbs_pkg::OP_READ: begin
          if (cmd_r != i2cmbs_pkg::CMD_IDLE) begin
            err = 1'b1;
          end else begin
            cmd_nxt  = i2cmbs_pkg::cmd_t'(op);
            step_nxt = '0;
            if (op == i2cmbs_pkg::OP_WRITE) begin
              shift_nxt = tx_byte;
            end
            if (op == i2cmbs_pkg::OP_READ) begin
              shift_nxt  = '0;
              no_ack_nxt = last_read;
            end
          end
        end
        i2cmbs_pkg::OP_TICK: begin
          if (cmd_r != i2cmbs_pkg::CMD_IDLE) begin
            case (sel.act)
              i2cmbs_pkg::ACT_CLK0: scl_nxt = 1'b0;
              i2cmbs_pkg::ACT_CLK1: scl_nxt = 1'b1;
              i2cmbs_pkg::ACT_REL:  sda_low_nxt = 1'b0;
              i2cmbs_pkg::ACT_PULL: sda_low_nxt = 1'b1;
              i2cmbs_pkg::ACT_DBIT: sda_low_nxt = ~shift_r[ByteW-1];
              i2cmbs_pkg::ACT_CLK1_ACK: begin
                scl_nxt = 1'b1;
                ack_nxt = ~sda_in;
              end
              i2cmbs_pkg::ACT_CLK1_BIT: begin
                scl_nxt   = 1'b1;
                shift_nxt = {shift_r[ByteW-2:0], sda_in};
              end
              default: begin
                scl_nxt   = 1'b0;
                shift_nxt = {shift_r[ByteW-2:0], 1'b0};
              end
            endcase
            if (sel.last) begin
              if (cmd_r == i2cmbs_pkg::CMD_READ) begin
                rx_nxt = shift_nxt;
              end
              cmd_nxt  = i2cmbs_pkg::CMD_IDLE;
              step_nxt = '0;
              done     = 1'b1;
            end else begin
              step_nxt = step_r + 1'b1;
            end
          end
        end
        default: begin
          // Undefined operation: nothing changes
          cmd_nxt = cmd_r;
        end
      endcase
    end
    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_pull_low = sda_low_nxt;
    res_nxt.busy_res     = (cmd_nxt != i2cmbs_pkg::CMD_IDLE);
    res_nxt.done_res     = done;
    res_nxt.rx_byte      = rx_nxt;
    res_nxt.ack_seen     = ack_nxt;
    res_nxt.cmd_error    = err;
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r     <= i2cmbs_pkg::CMD_IDLE;
      step_r    <= '0;
      shift_r   <= '0;
      rx_r      <= '0;
      no_ack_r  <= 1'b0;
      scl_r     <= 1'b1;
      sda_low_r <= 1'b0;
      ack_r     <= 1'b0;
    end else begin
      cmd_r     <= cmd_nxt;
      step_r    <= step_nxt;
      shift_r   <= shift_nxt;
      rx_r      <= rx_nxt;
      no_ack_r  <= no_ack_nxt;
      scl_r     <= scl_nxt;
      sda_low_r <= sda_low_nxt;
      ack_r     <= ack_nxt;
    end
  end

  // Advance results through the output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_nxt;
    end else if (in_fire) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  `ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_r || out_valid_r, "skid full while output empty")
  `ASSERT_ALWAYS(a_idle_step_zero, cmd_r != i2cmbs_pkg::CMD_IDLE || step_r == '0, "idle with nonzero step")
  `ASSERT_ALWAYS(a_step_bound, step_r <= i2cmbs_pkg::StepLastWrite, "step index past end of write")
  `ASSERT_NEXT(a_done_goes_idle, in_fire && res_nxt.done_res, cmd_r == i2cmbs_pkg::CMD_IDLE, "command not retired after done")
  `ASSERT_NEXT(a_error_holds_step, in_fire && res_nxt.cmd_error, $stable(step_r) && $stable(cmd_r), "rejected command moved the sequence")

endmodule
